FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/tba_pkg.sv
`timescale 1ns / 1ps

package tba_pkg;

  // Number of credit domains kept in state
  localparam int DOMAINS = 4;
  // Width of the domain field
  localparam int DOM_W = 2;
  // Bits needed to select one stored domain
  localparam int DOM_SEL_W = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  // Domain limit in the width of a widened domain field
  localparam logic [DOM_W:0] DOMAINS_LIM = (DOM_W + 1)'(DOMAINS);

  localparam int DATA_W = 32;
  localparam int FLOOR_REGS = 4;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DOMAIN0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SHARED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_EMERGENCY = 3'd5;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RELOAD  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [FLOOR_REGS-1:0][DATA_W-1:0] floor;
    logic [DATA_W-1:0]                 shared;
    logic [DATA_W-1:0]                 emergency;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [DOM_W-1:0]  domain;
    logic [DATA_W-1:0] units;
    logic              critical;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] granted;
    logic [DATA_W-1:0] domain_borrowed;
    logic [DATA_W-1:0] shared_left;
    logic [DATA_W-1:0] emergency_left;
  } result_t;

endpackage

FILE: hw/rtl/tba_cfg_regs.sv
`timescale 1ns / 1ps

module tba_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tba_pkg::DATA_W-1:0]    cfg_data,
  output tba_pkg::cfg_t                 cfg
);
  import tba_pkg::*;

  localparam logic [CFG_IDX_W-1:0] FLOOR_END = REG_FLOOR_DOMAIN0 + CFG_IDX_W'(FLOOR_REGS);

  logic [$clog2(FLOOR_REGS)-1:0] floor_sel;

  assign floor_sel = cfg_index[$clog2(FLOOR_REGS)-1:0];

  // Store register writes; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index < FLOOR_END) begin
        cfg.floor[floor_sel] <= cfg_data;
      end else if (cfg_index == REG_INITIAL_SHARED) begin
        cfg.shared <= cfg_data;
      end else if (cfg_index == REG_INITIAL_EMERGENCY) begin
        cfg.emergency <= cfg_data;
      end
    end
  end

endmodule

FILE: hw/rtl/tba_core.sv
`timescale 1ns / 1ps

module tba_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tba_pkg::item_t   item,
  input  tba_pkg::cfg_t    cfg,
  output tba_pkg::result_t res
);
  import tba_pkg::*;

  logic [DATA_W-1:0] remaining [DOMAINS];
  logic [DATA_W-1:0] borrowed [DOMAINS];
  logic [DATA_W-1:0] shared_pool;
  logic [DATA_W-1:0] emergency_pool;

  logic [DATA_W-1:0] remaining_next [DOMAINS];
  logic [DATA_W-1:0] borrowed_next [DOMAINS];
  logic [DATA_W-1:0] shared_pool_next;
  logic [DATA_W-1:0] emergency_pool_next;

  logic                 dom_ok;
  logic [DOM_SEL_W-1:0] dsel;
  logic [DATA_W-1:0]    rem_sel;
  logic [DATA_W-1:0]    bor_sel;
  logic [DATA_W-1:0]    take_own;
  logic [DATA_W-1:0]    take_shared;
  logic [DATA_W-1:0]    take_emg;
  logic [DATA_W-1:0]    want_shared;
  logic [DATA_W-1:0]    want_emg;
  logic [DATA_W+1:0]    bor_sum;
  logic [DATA_W-1:0]    bor_new;
  logic [DATA_W:0]      rel_sum;
  logic [DATA_W-1:0]    rel_shared;

  assign dom_ok  = ({1'b0, item.domain} < DOMAINS_LIM);
  assign dsel    = DOM_SEL_W'(item.domain);
  assign rem_sel = remaining[dsel];
  assign bor_sel = borrowed[dsel];

  // Take from own credit, then shared pool, then emergency reserve for critical requests
  always_comb begin
    take_own    = (rem_sel < item.units) ? rem_sel : item.units;
    want_shared = item.units - take_own;
    take_shared = (shared_pool < want_shared) ? shared_pool : want_shared;
    want_emg    = want_shared - take_shared;
    if (item.critical) begin
      take_emg = (emergency_pool < want_emg) ? emergency_pool : want_emg;
    end else begin
      take_emg = '0;
    end
  end

  // Saturate the borrowed total and the released shared pool
  always_comb begin
    bor_sum    = {2'b00, bor_sel} + {2'b00, take_shared} + {2'b00, take_emg};
    bor_new    = (|bor_sum[DATA_W+1:DATA_W]) ? '1 : bor_sum[DATA_W-1:0];
    rel_sum    = {1'b0, shared_pool} + {1'b0, rem_sel};
    rel_shared = rel_sum[DATA_W] ? '1 : rel_sum[DATA_W-1:0];
  end

  // Select the next state for the command
  always_comb begin
    for (int i = 0; i < DOMAINS; i++) begin
      remaining_next[i] = remaining[i];
      borrowed_next[i]  = borrowed[i];
    end
    shared_pool_next    = shared_pool;
    emergency_pool_next = emergency_pool;
    case (item.cmd)
      CMD_REQUEST: begin
        if (dom_ok) begin
          remaining_next[dsel] = rem_sel - take_own;
          borrowed_next[dsel]  = bor_new;
          shared_pool_next     = shared_pool - take_shared;
          emergency_pool_next  = emergency_pool - take_emg;
        end
      end
      CMD_RELEASE: begin
        if (dom_ok) begin
          remaining_next[dsel] = '0;
          shared_pool_next     = rel_shared;
        end
      end
      CMD_RELOAD: begin
        for (int i = 0; i < DOMAINS; i++) begin
          remaining_next[i] = cfg.floor[i];
          borrowed_next[i]  = '0;
        end
        shared_pool_next    = cfg.shared;
        emergency_pool_next = cfg.emergency;
      end
      default: begin
      end
    endcase
  end

  // Build the result of this transaction
  always_comb begin
    if (item.cmd == CMD_REQUEST && dom_ok) begin
      res.granted = take_own + take_shared + take_emg;
    end else begin
      res.granted = '0;
    end
    res.domain_borrowed = dom_ok ? borrowed_next[dsel] : '0;
    res.shared_left     = shared_pool_next;
    res.emergency_left  = emergency_pool_next;
  end

  // Commit the state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DOMAINS; i++) begin
        remaining[i] <= '0;
        borrowed[i]  <= '0;
      end
      shared_pool    <= '0;
      emergency_pool <= '0;
    end else if (step) begin
      for (int i = 0; i < DOMAINS; i++) begin
        remaining[i] <= remaining_next[i];
        borrowed[i]  <= borrowed_next[i];
      end
      shared_pool    <= shared_pool_next;
      emergency_pool <= emergency_pool_next;
    end
  end

endmodule

FILE: hw/rtl/tiered_budget_allocator_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   cmd, domain, units, critical
// out      output     out_valid/out_stall granted, domain_borrowed, shared_left,
//                                         emergency_left
// cfg      input      cfg_wr_en           cfg_index, cfg_data
//
// Takes one transaction per cycle unless the output stalls; it is held in the input
// register, its result in the output register. The core reads and rewrites the per-domain
// state on each step, which sets that rate. Reset is synchronous and clears state, config
// and both valid flags. A stalled output holds its result while one more transaction
// waits in the input register; further input is stalled until the output drains.

module tiered_budget_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic [tba_pkg::DOM_W-1:0]     domain,
  input  logic [tba_pkg::DATA_W-1:0]    units,
  input  logic                          critical,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tba_pkg::DATA_W-1:0]    granted,
  output logic [tba_pkg::DATA_W-1:0]    domain_borrowed,
  output logic [tba_pkg::DATA_W-1:0]    shared_left,
  output logic [tba_pkg::DATA_W-1:0]    emergency_left,
  input  logic                          cfg_wr_en,
  input  logic [tba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tba_pkg::DATA_W-1:0]    cfg_data
);
  import tba_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res_comb;
  result_t res;
  logic    item_valid;
  logic    advance;
  logic    in_take;

  tba_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tba_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res_comb)
  );

  // Move the held transaction on when the output register is free or draining
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Hold the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.cmd      <= cmd_e'(cmd);
      item.domain   <= domain;
      item.units    <= units;
      item.critical <= critical;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign granted         = res.granted;
  assign domain_borrowed = res.domain_borrowed;
  assign shared_left     = res.shared_left;
  assign emergency_left  = res.emergency_left;

endmodule

FILE: hw/rtl/tba_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tba_pkg::DATA_W-1:0]    granted,
  input logic [tba_pkg::DATA_W-1:0]    shared_left
);

  // A stalled result stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(granted) && $stable(shared_left))

  // Input only stalls while a result is held back
  `ASSERT_IMPL(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // No result comes out of reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind tiered_budget_allocator_top tba_checker u_tba_checker (.*);

FILE: tb/tiered_budget_allocator_top_tb.sv
`timescale 1ns / 1ps

module tiered_budget_allocator_top_tb;
  import tba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned IDLE_PCT = 26;
  // Number of indexes the config port can address, unused ones included
  localparam int unsigned REG_SLOTS = 1 << CFG_IDX_W;
  // Command code with no meaning to the block
  localparam cmd_e CMD_NONE = cmd_e'(2'd3);
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  // Tracks pool and domain credit and holds the grants still owed by the block
  class allocation_ledger;
    cfg_t              regs;
    logic [DATA_W-1:0] remaining [DOMAINS];
    logic [DATA_W-1:0] borrowed [DOMAINS];
    logic [DATA_W-1:0] shared_pool;
    logic [DATA_W-1:0] emergency_pool;
    result_t           pending [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      regs = '0;
      for (int i = 0; i < DOMAINS; i++) begin
        remaining[i] = '0;
        borrowed[i] = '0;
      end
      shared_pool = '0;
      emergency_pool = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      errors++;
      // keep the log short when the block is badly off
      if (errors <= 40) $display("ERROR: %s", msg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx < FLOOR_REGS) begin
        regs.floor[idx] = val;
      end else if (idx == REG_INITIAL_SHARED) begin
        regs.shared = val;
      end else if (idx == REG_INITIAL_EMERGENCY) begin
        regs.emergency = val;
      end
      // other indexes are dropped by the block
    endfunction

    function logic [DATA_W-1:0] sat_add(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DATA_W] ? ALL_ONES : s[DATA_W-1:0];
    endfunction

    function logic [DATA_W-1:0] min_of(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      return (a < b) ? a : b;
    endfunction

    // Apply one transaction to the credit state and return the result it yields
    function result_t allocate(item_t it);
      result_t           r;
      logic [DATA_W-1:0] want;
      logic [DATA_W-1:0] take;
      int unsigned       d;
      r = '0;
      d = it.domain;
      case (it.cmd)
        CMD_REQUEST: begin
          if (d < DOMAINS && it.units != '0) begin
            // own credit first
            want = it.units;
            take = min_of(remaining[d], want);
            remaining[d] -= take;
            want -= take;
            r.granted += take;
            // then the shared surplus, counted as borrowed
            if (want != '0) begin
              take = min_of(shared_pool, want);
              shared_pool -= take;
              borrowed[d] = sat_add(borrowed[d], take);
              want -= take;
              r.granted += take;
            end
            // critical requests may dip into the emergency reserve
            if (it.critical && want != '0) begin
              take = min_of(emergency_pool, want);
              emergency_pool -= take;
              borrowed[d] = sat_add(borrowed[d], take);
              r.granted += take;
            end
          end
        end
        CMD_RELEASE: begin
          if (d < DOMAINS) begin
            shared_pool = sat_add(shared_pool, remaining[d]);
            remaining[d] = '0;
          end
        end
        CMD_RELOAD: begin
          for (int i = 0; i < DOMAINS; i++) begin
            remaining[i] = regs.floor[i % FLOOR_REGS];
            borrowed[i] = '0;
          end
          shared_pool = regs.shared;
          emergency_pool = regs.emergency;
        end
        default: ;
      endcase
      r.domain_borrowed = (d < DOMAINS) ? borrowed[d] : '0;
      r.shared_left = shared_pool;
      r.emergency_left = emergency_pool;
      return r;
    endfunction

    function void note_request(item_t it);
      pending.push_back(allocate(it));
    endfunction

    function void check_grant(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing owed: granted %h", got.granted));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.granted !== want.granted)
        report($sformatf("granted %h, predicted %h", got.granted, want.granted));
      if (got.domain_borrowed !== want.domain_borrowed)
        report($sformatf("domain_borrowed %h, predicted %h",
                         got.domain_borrowed, want.domain_borrowed));
      if (got.shared_left !== want.shared_left)
        report($sformatf("shared_left %h, predicted %h", got.shared_left, want.shared_left));
      if (got.emergency_left !== want.emergency_left)
        report($sformatf("emergency_left %h, predicted %h",
                         got.emergency_left, want.emergency_left));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd = '0;
  logic [DOM_W-1:0]     domain = '0;
  logic [DATA_W-1:0]    units = '0;
  logic                 critical = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    granted;
  logic [DATA_W-1:0]    domain_borrowed;
  logic [DATA_W-1:0]    shared_left;
  logic [DATA_W-1:0]    emergency_left;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  allocation_ledger ledger = new();
  bit               steady = 1'b0;
  int unsigned      cycles = 0;
  int unsigned      per_cmd [4] = '{default: 0};
  int unsigned      settings = 0;

  tiered_budget_allocator_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .domain         (domain),
    .units          (units),
    .critical       (critical),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted        (granted),
    .domain_borrowed(domain_borrowed),
    .shared_left    (shared_left),
    .emergency_left (emergency_left),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result channel at random, except during the steady stretch
  always @(posedge clk) begin
    if (rst || steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Check every result transaction against the oldest owed grant
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      ledger.check_grant({granted, domain_borrowed, shared_left, emergency_left});
    end
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: no progress after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic item_t make_item(cmd_e c, int unsigned d, logic [DATA_W-1:0] u, bit crit);
    item_t it;
    it.cmd = c;
    it.domain = d[DOM_W-1:0];
    it.units = u;
    it.critical = crit;
    return it;
  endfunction

  // Pick pool sizes and floors: mostly small so pools run dry, some extremes
  function automatic logic [DATA_W-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return ALL_ONES;
    if (roll < 60) return $urandom_range(1, 100);
    if (roll < 80) return $urandom_range(101, 5000);
    return $urandom;
  endfunction

  function automatic logic [DATA_W-1:0] pick_units();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 13) return ALL_ONES;
    if (roll < 63) return $urandom_range(1, 40);
    if (roll < 80) return $urandom_range(41, 2000);
    return $urandom;
  endfunction

  function automatic item_t pick_item();
    int unsigned roll;
    cmd_e        c;
    roll = $urandom_range(0, 99);
    if (roll < 68) c = CMD_REQUEST;
    else if (roll < 80) c = CMD_RELEASE;
    else if (roll < 92) c = CMD_RELOAD;
    else c = CMD_NONE;
    return make_item(c, $urandom_range(0, 3), pick_units(), $urandom_range(0, 1));
  endfunction

  // Present one transaction, idling at random first, and hold it until taken
  task automatic send_item(item_t it);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    domain <= it.domain;
    units <= it.units;
    critical <= it.critical;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_request(it);
    per_cmd[it.cmd]++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
  endtask

  // Write every config index, the unused ones too; block must be idle
  task automatic program_regs(input logic [DATA_W-1:0] vals [REG_SLOTS]);
    for (int i = 0; i < REG_SLOTS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      ledger.set_reg(i[CFG_IDX_W-1:0], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [DATA_W-1:0] levels [REG_SLOTS];

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Everything empty after reset: nothing can be granted
    send_item(make_item(CMD_REQUEST, 0, ALL_ONES, 1'b1));
    send_item(make_item(CMD_REQUEST, 1, '0, 1'b0));
    send_item(make_item(CMD_NONE, 3, ALL_ONES, 1'b1));
    send_item(make_item(CMD_RELEASE, 2, '0, 1'b0));
    send_item(make_item(CMD_RELOAD, 1, 32'h1234, 1'b1));
    settle();

    // Extreme floors and pools to reach saturation and every tier
    levels[REG_FLOOR_DOMAIN0] = ALL_ONES;
    levels[REG_FLOOR_DOMAIN0 + 1] = 32'd16;
    levels[REG_FLOOR_DOMAIN0 + 2] = '0;
    levels[REG_FLOOR_DOMAIN0 + 3] = 32'h8000_0000;
    levels[REG_INITIAL_SHARED] = 32'hFFFF_FFF0;
    levels[REG_INITIAL_EMERGENCY] = ALL_ONES;
    for (int i = REG_INITIAL_EMERGENCY + 1; i < REG_SLOTS; i++) levels[i] = ALL_ONES;
    program_regs(levels);
    send_item(make_item(CMD_RELOAD, 0, '0, 1'b0));
    send_item(make_item(CMD_REQUEST, 0, ALL_ONES, 1'b0));
    send_item(make_item(CMD_REQUEST, 1, '0, 1'b1));
    // own credit runs out, rest from shared
    send_item(make_item(CMD_REQUEST, 1, 32'h20, 1'b0));
    // shared pool saturates on this release
    send_item(make_item(CMD_RELEASE, 3, '0, 1'b0));
    send_item(make_item(CMD_REQUEST, 2, 32'hFFFF_FFF0, 1'b0));
    // borrowed total saturates as emergency covers the shortfall
    send_item(make_item(CMD_REQUEST, 2, ALL_ONES, 1'b1));
    send_item(make_item(CMD_REQUEST, 2, 32'd7, 1'b1));
    send_item(make_item(CMD_REQUEST, 3, 32'd1, 1'b0));
    send_item(make_item(CMD_REQUEST, 3, 32'd5, 1'b1));
    send_item(make_item(CMD_NONE, 0, 32'h5555_5555, 1'b0));
    send_item(make_item(CMD_RELEASE, 0, '0, 1'b1));
    send_item(make_item(CMD_REQUEST, 1, ALL_ONES, 1'b1));
    send_item(make_item(CMD_RELOAD, 2, ALL_ONES, 1'b1));
    send_item(make_item(CMD_REQUEST, 3, 32'h8000_0001, 1'b0));
    settle();

    // Random phases: all-max, all-zero, then mixed settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < REG_SLOTS; i++) begin
        if (p == 0) levels[i] = ALL_ONES;
        else if (p == 1) levels[i] = '0;
        else levels[i] = pick_level();
      end
      program_regs(levels);
      steady = (p == 2);
      send_item(make_item(CMD_RELOAD, 0, '0, 1'b0));
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        // hold off mid-phase until the block has drained
        if (p == 3 && n == PHASE_ITEMS / 2) settle();
        send_item(pick_item());
      end
      steady = 1'b0;
      settle();
    end

    repeat (8) @(posedge clk);
    if (ledger.pending.size() != 0)
      ledger.report($sformatf("%0d results never came", ledger.pending.size()));
    $display("summary: %0d requests, %0d releases, %0d reloads, %0d idle commands, %0d settings",
             per_cmd[CMD_REQUEST], per_cmd[CMD_RELEASE], per_cmd[CMD_RELOAD],
             per_cmd[CMD_NONE], settings);
    $display("summary: %0d results checked, %0d mismatches, %0d cycles",
             ledger.checked, ledger.errors, cycles);
    if (ledger.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: tiered_budget_allocator_top.f
+incdir+hw/rtl
hw/rtl/tba_pkg.sv
hw/rtl/tba_cfg_regs.sv
hw/rtl/tba_core.sv
hw/rtl/tiered_budget_allocator_top.sv
hw/rtl/tba_checker.sv
tb/tiered_budget_allocator_top_tb.sv
